>>> hw/rtl/hsv_to_rgb_sector_defines.svh
// assertion macros used by the checker file
`ifndef HSV_TO_RGB_SECTOR_DEFINES_SVH
`define HSV_TO_RGB_SECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define HSVRGB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define HSVRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/hsvrgb_pkg.sv
// shared types, widths and constants of the hsv to rgb converter
`timescale 1ns / 1ps

package hsvrgb_pkg;

	localparam int HUE_W = 16;
	localparam int CH_W  = 8;
	localparam int SEC_W = 3;
	localparam int DEN_W = 24;
	localparam int NUM_W = 32;

	localparam int HUE_BITS_PER_STAGE_DEF = 2;

	localparam logic [HUE_W-1:0] SECTOR_WIDTH_RST = 16'd11850;
	localparam logic [HUE_W-1:0] HUE_TOP          = 16'hFFFF;
	localparam logic [CH_W-1:0]  CH_MAX           = 8'd255;

	// color sectors, anything past the fifth folds into the last one
	localparam logic [SEC_W-1:0] SEC_0 = 3'd0;
	localparam logic [SEC_W-1:0] SEC_1 = 3'd1;
	localparam logic [SEC_W-1:0] SEC_2 = 3'd2;
	localparam logic [SEC_W-1:0] SEC_3 = 3'd3;
	localparam logic [SEC_W-1:0] SEC_4 = 3'd4;
	localparam logic [SEC_W-1:0] SEC_5 = 3'd5;

	typedef struct packed {
		logic [CH_W-1:0] bri;
		logic [CH_W-1:0] sat;
	} pix_t;

	typedef struct packed {
		logic [CH_W-1:0]  bri;
		logic [CH_W-1:0]  p;
		logic [SEC_W-1:0] sec;
	} side_t;

endpackage

>>> hw/rtl/hsvrgb_if.sv
// valid/ready channel interfaces for hsv input and rgb output
`timescale 1ns / 1ps

interface hsvrgb_hsv_if;
	logic                          valid;
	logic                          ready;
	logic [hsvrgb_pkg::CH_W-1:0]   brightness;
	logic [hsvrgb_pkg::HUE_W-1:0]  hue_angle;
	logic [hsvrgb_pkg::CH_W-1:0]   saturation;

	modport source (output valid, brightness, hue_angle, saturation, input ready);
	modport sink (input valid, brightness, hue_angle, saturation, output ready);
endinterface

interface hsvrgb_rgb_if;
	logic                        valid;
	logic                        ready;
	logic [hsvrgb_pkg::CH_W-1:0] red;
	logic [hsvrgb_pkg::CH_W-1:0] green;
	logic [hsvrgb_pkg::CH_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

>>> hw/rtl/hsvrgb_hue_div.sv
// pipelined restoring divider: hue by sector width, gives sector and remainder
`timescale 1ns / 1ps

module hsvrgb_hue_div #(
	parameter int BITS_PER_STAGE = hsvrgb_pkg::HUE_BITS_PER_STAGE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_valid,
	input  logic [hsvrgb_pkg::HUE_W-1:0]    in_hue,
	input  hsvrgb_pkg::pix_t                in_side,
	input  logic [hsvrgb_pkg::HUE_W-1:0]    width,
	output logic                            out_valid,
	output logic [hsvrgb_pkg::SEC_W-1:0]    out_sec,
	output logic [hsvrgb_pkg::HUE_W-1:0]    out_rem,
	output hsvrgb_pkg::pix_t                out_side
);

	localparam int HUE_W  = hsvrgb_pkg::HUE_W;
	localparam int STAGES = HUE_W / BITS_PER_STAGE;

	typedef struct packed {
		logic [HUE_W-1:0] r;
		logic [HUE_W-1:0] d;
		logic [HUE_W-1:0] q;
	} div_st_t;

	// BITS_PER_STAGE shift/compare/subtract steps on the partial remainder
	function automatic div_st_t hue_steps(div_st_t x, logic [HUE_W-1:0] w);
		div_st_t          y;
		logic [HUE_W:0]   trial;
		y = x;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			trial = {y.r, y.d[HUE_W-1]};
			y.d   = {y.d[HUE_W-2:0], 1'b0};
			if (trial >= {1'b0, w}) begin
				y.r = HUE_W'(trial - {1'b0, w});
				y.q = {y.q[HUE_W-2:0], 1'b1};
			end else begin
				y.r = trial[HUE_W-1:0];
				y.q = {y.q[HUE_W-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	div_st_t          st_in;
	div_st_t          st_s   [STAGES];
	hsvrgb_pkg::pix_t side_s [STAGES];
	logic [STAGES-1:0] vld_s;

	assign st_in = '{r: '0, d: in_hue, q: '0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int g = 1; g < STAGES; g++) begin
				vld_s[g] <= vld_s[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0]   <= hue_steps(st_in, width);
			side_s[0] <= in_side;
			for (int g = 1; g < STAGES; g++) begin
				st_s[g]   <= hue_steps(st_s[g-1], width);
				side_s[g] <= side_s[g-1];
			end
		end
	end

	// quotient of five or more folds into the last sector
	assign out_valid = vld_s[STAGES-1];
	assign out_rem   = st_s[STAGES-1].r;
	assign out_side  = side_s[STAGES-1];
	assign out_sec   = (st_s[STAGES-1].q >= HUE_W'(hsvrgb_pkg::SEC_5)) ? hsvrgb_pkg::SEC_5
		: st_s[STAGES-1].q[hsvrgb_pkg::SEC_W-1:0];

endmodule

>>> hw/rtl/hsvrgb_pqt.sv
// three-stage datapath forming p and the q/t numerators over 255*width
`timescale 1ns / 1ps

module hsvrgb_pqt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_valid,
	input  logic [hsvrgb_pkg::SEC_W-1:0]    in_sec,
	input  logic [hsvrgb_pkg::HUE_W-1:0]    in_rem,
	input  hsvrgb_pkg::pix_t                in_side,
	input  logic [hsvrgb_pkg::HUE_W-1:0]    width,
	output logic                            out_valid,
	output logic [hsvrgb_pkg::NUM_W-1:0]    out_nq,
	output logic [hsvrgb_pkg::NUM_W-1:0]    out_nt,
	output logic [hsvrgb_pkg::DEN_W-1:0]    out_den,
	output hsvrgb_pkg::side_t               out_side
);

	localparam int CH_W  = hsvrgb_pkg::CH_W;
	localparam int HUE_W = hsvrgb_pkg::HUE_W;
	localparam int DEN_W = hsvrgb_pkg::DEN_W;
	localparam int NUM_W = hsvrgb_pkg::NUM_W;
	localparam int PN_W  = 2 * CH_W;
	localparam int PM_W  = PN_W + CH_W + 1;
	// floor(x/255) estimate as x*257 >> 16, low by at most one
	localparam logic [CH_W:0] RECIP_255 = 9'd257;

	logic                          vld_s1, vld_s2, vld_s3;
	logic [CH_W-1:0]               bri_s1, bri_s2, bri_s3;
	logic [hsvrgb_pkg::SEC_W-1:0]  sec_s1, sec_s2, sec_s3;
	logic [DEN_W-1:0]              den_s1, den_s2, den_s3;
	logic [DEN_W-1:0]              sq_s1, st_s1;
	logic [DEN_W-1:0]              dq_s2, dt_s2;
	logic [PN_W-1:0]               pn_s1, pn_s2;
	logic [CH_W-1:0]               pa_s2, p_s3;
	logic [NUM_W-1:0]              nq_s3, nt_s3;

	logic [PM_W-1:0]               pm;
	logic [PN_W-1:0]               pa255, prem;

	assign pm    = PM_W'(pn_s1) * PM_W'(RECIP_255);
	assign pa255 = {pa_s2, {CH_W{1'b0}}} - {{CH_W{1'b0}}, pa_s2};
	assign prem  = pn_s2 - pa255;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// products of saturation with remainder and with its complement
			den_s1 <= {width, {CH_W{1'b0}}} - {{CH_W{1'b0}}, width};
			sq_s1  <= DEN_W'(in_side.sat) * DEN_W'(in_rem);
			st_s1  <= DEN_W'(in_side.sat) * DEN_W'(width - in_rem);
			pn_s1  <= PN_W'(in_side.bri) * PN_W'(hsvrgb_pkg::CH_MAX - in_side.sat);
			bri_s1 <= in_side.bri;
			sec_s1 <= in_sec;

			dq_s2  <= den_s1 - sq_s1;
			dt_s2  <= den_s1 - st_s1;
			pa_s2  <= pm[PN_W+CH_W-1:PN_W];
			pn_s2  <= pn_s1;
			den_s2 <= den_s1;
			bri_s2 <= bri_s1;
			sec_s2 <= sec_s1;

			nq_s3  <= NUM_W'(bri_s2) * NUM_W'(dq_s2);
			nt_s3  <= NUM_W'(bri_s2) * NUM_W'(dt_s2);
			p_s3   <= (prem >= PN_W'(hsvrgb_pkg::CH_MAX)) ? CH_W'(pa_s2 + 8'd1) : pa_s2;
			den_s3 <= den_s2;
			bri_s3 <= bri_s2;
			sec_s3 <= sec_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_nq    = nq_s3;
	assign out_nt    = nt_s3;
	assign out_den   = den_s3;
	assign out_side  = '{bri: bri_s3, p: p_s3, sec: sec_s3};

endmodule

>>> hw/rtl/hsvrgb_frac_div.sv
// two-lane pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module hsvrgb_frac_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_valid,
	input  logic [hsvrgb_pkg::NUM_W-1:0]    in_nq,
	input  logic [hsvrgb_pkg::NUM_W-1:0]    in_nt,
	input  logic [hsvrgb_pkg::DEN_W-1:0]    in_den,
	input  hsvrgb_pkg::side_t               in_side,
	output logic                            out_valid,
	output logic [hsvrgb_pkg::CH_W-1:0]     out_q,
	output logic [hsvrgb_pkg::CH_W-1:0]     out_t,
	output hsvrgb_pkg::side_t               out_side
);

	localparam int STEPS = hsvrgb_pkg::CH_W;
	localparam int NUM_W = hsvrgb_pkg::NUM_W;
	localparam int DEN_W = hsvrgb_pkg::DEN_W;

	typedef struct packed {
		logic [NUM_W-1:0] rq;
		logic [NUM_W-1:0] rt;
		logic [STEPS-1:0] qq;
		logic [STEPS-1:0] qt;
		logic [DEN_W-1:0] den;
	} fd_st_t;

	// quotient below 256, so the msb comes from den << 7
	function automatic fd_st_t fd_step(fd_st_t x, int sh);
		logic [NUM_W-1:0] dsh;
		fd_st_t           y;
		dsh = NUM_W'(x.den) << sh;
		y   = x;
		if (x.rq >= dsh) begin
			y.rq = x.rq - dsh;
			y.qq = {x.qq[STEPS-2:0], 1'b1};
		end else begin
			y.qq = {x.qq[STEPS-2:0], 1'b0};
		end
		if (x.rt >= dsh) begin
			y.rt = x.rt - dsh;
			y.qt = {x.qt[STEPS-2:0], 1'b1};
		end else begin
			y.qt = {x.qt[STEPS-2:0], 1'b0};
		end
		return y;
	endfunction

	fd_st_t            st_in;
	fd_st_t            st_s   [STEPS];
	hsvrgb_pkg::side_t side_s [STEPS];
	logic [STEPS-1:0]  vld_s;

	assign st_in = '{rq: in_nq, rt: in_nt, qq: '0, qt: '0, den: in_den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int g = 1; g < STEPS; g++) begin
				vld_s[g] <= vld_s[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0]   <= fd_step(st_in, STEPS - 1);
			side_s[0] <= in_side;
			for (int g = 1; g < STEPS; g++) begin
				st_s[g]   <= fd_step(st_s[g-1], STEPS - 1 - g);
				side_s[g] <= side_s[g-1];
			end
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_q     = st_s[STEPS-1].qq;
	assign out_t     = st_s[STEPS-1].qt;
	assign out_side  = side_s[STEPS-1];

endmodule

>>> hw/rtl/hsv_to_rgb_sector.sv
// top level of the hsv to rgb converter with configurable sector width
//
//   channel  dir  handshake       payload
//   hsv      in   valid / ready   brightness[7:0] hue_angle[15:0] saturation[7:0]
//   rgb      out  valid / ready   red[7:0] green[7:0] blue[7:0]
//   cfg      in   cfg_we          cfg_wdata[15:0] -> sector_width
//
// one transfer per cycle in and out while the output is not stalled; the stages in order
//   (hue divider stages, three multiply stages, eight q/t divider stages, output)
// the q/t divider stages give one quotient bit each; all stages together set the depth of the pipe
// reset clears every valid bit and loads sector_width with 11850
// the whole pipe holds while the output carries a result not yet taken;
//   hsv.ready is low exactly then
`timescale 1ns / 1ps

module hsv_to_rgb_sector #(
	parameter int HUE_BITS_PER_STAGE = hsvrgb_pkg::HUE_BITS_PER_STAGE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	hsvrgb_hsv_if.sink                    hsv,
	hsvrgb_rgb_if.source                  rgb,
	input  logic                          cfg_we,
	input  logic [hsvrgb_pkg::HUE_W-1:0]  cfg_wdata
);

	localparam int CH_W  = hsvrgb_pkg::CH_W;
	localparam int HUE_W = hsvrgb_pkg::HUE_W;

	// sector width register, zero behaves as one
	logic [HUE_W-1:0] sector_width_q;
	logic [HUE_W-1:0] width_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_width_q <= hsvrgb_pkg::SECTOR_WIDTH_RST;
		end else if (cfg_we) begin
			sector_width_q <= cfg_wdata;
		end
	end

	assign width_eff = (sector_width_q == '0) ? HUE_W'(1) : sector_width_q;

	// global advance: everything moves unless the output is stuck
	logic adv;
	logic out_vld_q;

	assign adv       = !out_vld_q || rgb.ready;
	assign hsv.ready = adv;

	// top hue value wraps to zero
	logic [HUE_W-1:0]  hue_fix;
	hsvrgb_pkg::pix_t  pix_in;

	assign hue_fix = (hsv.hue_angle == hsvrgb_pkg::HUE_TOP) ? '0 : hsv.hue_angle;
	assign pix_in  = '{bri: hsv.brightness, sat: hsv.saturation};

	// hue / width
	logic                          hd_valid;
	logic [hsvrgb_pkg::SEC_W-1:0]  hd_sec;
	logic [HUE_W-1:0]              hd_rem;
	hsvrgb_pkg::pix_t              hd_side;

	hsvrgb_hue_div #(
		.BITS_PER_STAGE (HUE_BITS_PER_STAGE)
	) u_hue_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (hsv.valid),
		.in_hue    (hue_fix),
		.in_side   (pix_in),
		.width     (width_eff),
		.out_valid (hd_valid),
		.out_sec   (hd_sec),
		.out_rem   (hd_rem),
		.out_side  (hd_side)
	);

	// p directly, q and t as numerators over 255*width
	logic                          pq_valid;
	logic [hsvrgb_pkg::NUM_W-1:0]  pq_nq, pq_nt;
	logic [hsvrgb_pkg::DEN_W-1:0]  pq_den;
	hsvrgb_pkg::side_t             pq_side;

	hsvrgb_pqt u_pqt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (hd_valid),
		.in_sec    (hd_sec),
		.in_rem    (hd_rem),
		.in_side   (hd_side),
		.width     (width_eff),
		.out_valid (pq_valid),
		.out_nq    (pq_nq),
		.out_nt    (pq_nt),
		.out_den   (pq_den),
		.out_side  (pq_side)
	);

	// floor division of both numerators
	logic              fd_valid;
	logic [CH_W-1:0]   fd_q, fd_t;
	hsvrgb_pkg::side_t fd_side;

	hsvrgb_frac_div u_frac_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pq_valid),
		.in_nq     (pq_nq),
		.in_nt     (pq_nt),
		.in_den    (pq_den),
		.in_side   (pq_side),
		.out_valid (fd_valid),
		.out_q     (fd_q),
		.out_t     (fd_t),
		.out_side  (fd_side)
	);

	// sector select into the output register
	logic [CH_W-1:0] red_nx, green_nx, blue_nx;
	logic [CH_W-1:0] red_q, green_q, blue_q;

	always_comb begin
		unique case (fd_side.sec)
			hsvrgb_pkg::SEC_0: begin
				red_nx = fd_side.bri; green_nx = fd_t;        blue_nx = fd_side.p;
			end
			hsvrgb_pkg::SEC_1: begin
				red_nx = fd_q;        green_nx = fd_side.bri; blue_nx = fd_side.p;
			end
			hsvrgb_pkg::SEC_2: begin
				red_nx = fd_side.p;   green_nx = fd_side.bri; blue_nx = fd_t;
			end
			hsvrgb_pkg::SEC_3: begin
				red_nx = fd_side.p;   green_nx = fd_q;        blue_nx = fd_side.bri;
			end
			hsvrgb_pkg::SEC_4: begin
				red_nx = fd_t;        green_nx = fd_side.p;   blue_nx = fd_side.bri;
			end
			// last sector
			default: begin
				red_nx = fd_side.bri; green_nx = fd_side.p;   blue_nx = fd_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= fd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fd_valid) begin
			red_q   <= red_nx;
			green_q <= green_nx;
			blue_q  <= blue_nx;
		end
	end

	assign rgb.valid = out_vld_q;
	assign rgb.red   = red_q;
	assign rgb.green = green_q;
	assign rgb.blue  = blue_q;

endmodule

>>> hw/rtl/hsvrgb_chk.sv
// port-level checker for the hsv to rgb converter, bound to the top level
`timescale 1ns / 1ps
`include "hsv_to_rgb_sector_defines.svh"

module hsvrgb_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [hsvrgb_pkg::CH_W-1:0] red,
	input logic [hsvrgb_pkg::CH_W-1:0] green,
	input logic [hsvrgb_pkg::CH_W-1:0] blue
);

	// a stalled result stays put
	`HSVRGB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue), "rgb result changed or dropped while stalled")

	// a stuck output freezes the pipe, so no input transfer
	`HSVRGB_ASSERT_NOW(a_stall_blocks_in, out_valid && !out_ready, !in_ready, "input taken while output stalled")

	// with the output free the pipe always takes input
	`HSVRGB_ASSERT_NOW(a_free_takes_in, !out_valid || out_ready, in_ready, "input refused while output free")

	// handshake lines never go unknown once out of reset
	`HSVRGB_ASSERT_NOW(a_known_handshake, 1'b1, !$isunknown({in_valid, in_ready, out_valid, out_ready}), "unknown value on a handshake line")

endmodule

bind hsv_to_rgb_sector hsvrgb_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (hsv.valid),
	.in_ready  (hsv.ready),
	.out_valid (rgb.valid),
	.out_ready (rgb.ready),
	.red       (rgb.red),
	.green     (rgb.green),
	.blue      (rgb.blue)
);
